/* hw/rtl/srt_pkg.sv */
// Package: shared constants, types and the bucket hash for the registration table.
package srt_pkg;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned HASH_W     = 8;
  // Entry word: family, addr_high, addr_low, port, scope, expiry, bucket
  localparam int unsigned ENTRY_W    = 1 + 64 + 64 + 16 + 32 + 32 + HASH_W;
  localparam int unsigned IN_TDATA_W = 210;
  localparam int unsigned OUT_DATA_W = 28;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DAT_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_MIX_PORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd3;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_QUOTA    = 3'd3;
  localparam logic [2:0] ST_LOOPBACK = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SWEEP,
    S_WRITE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;       // latch request, reset pointer
    logic scan;        // bucket scan step
    logic sweep;       // table-wide expiry sweep step
    logic decide;      // resolve status before any sweep
    logic write;       // write new entry
  } cmd_t;

  typedef struct packed {
    logic last_slot;   // pointer at final slot (read data of it present)
    logic need_sweep;  // add path with a full table
    logic need_write;  // add path accepted so far
  } sts_t;

  function automatic logic [HASH_W-1:0] fold_hash(input logic v6, input logic [63:0] ah,
                                                  input logic [15:0] port, input logic mix);
    logic [31:0] h;
    logic [15:0] f;
    h = v6 ? (ah[63:32] ^ ah[31:0]) : ah[31:0];
    if (mix) h = h ^ {16'h0000, port};
    f = h[15:0] ^ h[31:16];
    return f[HASH_W-1:0] ^ f[2*HASH_W-1:HASH_W];
  endfunction

endpackage

/* hw/rtl/srt_ram.sv */
// Generic single-port-write RAM with registered read.
module srt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/srt_ctrl.sv */
// Controller: sequences scan, decision, sweep, write and result phases.
module srt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  srt_pkg::sts_t  sts_i,
  output srt_pkg::cmd_t  cmd_o
);
  srt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      srt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = srt_pkg::S_SCAN;
        end
      end
      srt_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last_slot) state_d = srt_pkg::S_DECIDE;
      end
      srt_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.need_sweep)      state_d = srt_pkg::S_SWEEP;
        else if (sts_i.need_write) state_d = srt_pkg::S_WRITE;
        else                       state_d = srt_pkg::S_OUT;
      end
      srt_pkg::S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.last_slot) state_d = srt_pkg::S_WRITE;
      end
      srt_pkg::S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = srt_pkg::S_OUT;
      end
      srt_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = srt_pkg::S_IDLE;
      end
      default: state_d = srt_pkg::S_IDLE;
    endcase
  end
endmodule

/* hw/rtl/srt_dp.sv */
// Datapath: request latch, entry memory, used bits, counters and result.
module srt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srt_pkg::cmd_t                 cmd_i,
  output srt_pkg::sts_t                 sts_o,
  input  logic [srt_pkg::IN_TDATA_W-1:0] in_data_i,
  input  logic                          in_kind_i,
  input  logic                          mix_i,
  input  logic                          loop_ok_i,
  input  logic [8:0]                    quota_i,
  input  logic [7:0]                    life_i,
  output logic [srt_pkg::OUT_DATA_W-1:0] out_data_o
);
  localparam int unsigned SW = srt_pkg::SLOT_W;
  localparam int unsigned CW = srt_pkg::CNT_W;

  // Request
  logic        kind_q, v6_q, map_q;
  logic [63:0] ah_q, al_q;
  logic [15:0] port_q;
  logic [31:0] scope_q, now_q;
  logic [srt_pkg::HASH_W-1:0] bkt_q;

  // Table state
  logic [srt_pkg::SLOTS-1:0] used_q;
  logic [CW-1:0]             live_q;

  // Scan state: ptr is address presented, rd_ptr the slot whose data arrives
  logic [SW:0]   ptr_q;
  logic          rd_vld_q;
  logic [SW-1:0] rd_ptr_q;
  logic          found_q;
  logic [SW-1:0] slot_q;
  logic [CW-1:0] same_q;
  logic          free_q;
  logic [SW-1:0] free_slot_q;
  logic [2:0]    stat_q;
  logic [31:0]   exp_q;

  logic [srt_pkg::ENTRY_W-1:0] rdata, wdata;
  logic        e_fam;
  logic [63:0] e_ah, e_al;
  logic [15:0] e_port;
  logic [31:0] e_scope, e_exp;
  logic [srt_pkg::HASH_W-1:0] e_bkt;

  logic        step, rd_used, hit_bkt, expired, evict, pub_eq, exact;
  logic [32:0] exp_sum;
  logic        loop;
  logic        v6_in;
  logic [63:0] ah_in;
  logic        ram_we;

  assign {e_fam, e_ah, e_al, e_port, e_scope, e_exp, e_bkt} = rdata;
  assign wdata = {v6_q, ah_q, al_q, port_q, scope_q, exp_q, bkt_q};

  // Write only when a free slot was found
  assign ram_we = cmd_i.write & free_q;

  srt_ram #(.WIDTH(srt_pkg::ENTRY_W), .DEPTH(srt_pkg::SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_slot_q),
    .wdata_i (wdata),
    .raddr_i (ptr_q[SW-1:0]),
    .rdata_o (rdata)
  );

  assign step    = cmd_i.scan | cmd_i.sweep;
  assign rd_used = rd_vld_q & used_q[rd_ptr_q];
  assign expired = e_exp < now_q;
  assign hit_bkt = rd_used & (e_fam == v6_q) & (e_bkt == bkt_q);
  assign evict   = cmd_i.scan ? (hit_bkt & expired) : (cmd_i.sweep & rd_used & expired);
  assign pub_eq  = e_ah == ah_q;
  assign exact   = pub_eq & (e_port == port_q) &
                   (!v6_q | ((e_al == al_q) & (e_scope == scope_q)));
  assign loop    = v6_q ? ((ah_q == 64'd0) & (al_q == 64'd1))
                        : ((ah_q[31:24] == 8'd127) & !map_q);
  assign exp_sum = {1'b0, now_q} + {25'd0, life_i};

  assign sts_o.last_slot  = rd_vld_q & (rd_ptr_q == SW'(srt_pkg::SLOTS - 1));
  assign sts_o.need_write = !found_q & kind_q & !((quota_i != '0) & (same_q >= quota_i))
                            & !(!loop_ok_i & loop);
  assign sts_o.need_sweep = sts_o.need_write & (live_q >= CW'(srt_pkg::SLOTS));

  assign v6_in = in_data_i[1];
  assign ah_in = v6_in ? in_data_i[65:2] : {32'd0, in_data_i[33:2]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q  <= in_kind_i;
      v6_q    <= v6_in;
      map_q   <= in_data_i[0];
      ah_q    <= ah_in;
      al_q    <= v6_in ? in_data_i[129:66] : 64'd0;
      port_q  <= in_data_i[145:130];
      scope_q <= v6_in ? in_data_i[177:146] : 32'd0;
      now_q   <= in_data_i[209:178];
      bkt_q   <= srt_pkg::fold_hash(v6_in, ah_in, in_data_i[145:130], mix_i);
      same_q  <= '0;
      found_q <= 1'b0;
      slot_q  <= '0;
      free_q  <= 1'b0;
    end else begin
      if (cmd_i.scan && hit_bkt && !expired && pub_eq) begin
        same_q <= same_q + 1'b1;
        if (!found_q && exact) begin
          found_q <= 1'b1;
          slot_q  <= rd_ptr_q;
        end
      end
      // Track lowest free slot; evicted slots count as free
      if (step && rd_vld_q && !free_q && (!used_q[rd_ptr_q] || evict)) begin
        free_q      <= 1'b1;
        free_slot_q <= rd_ptr_q;
      end
      if (cmd_i.decide) begin
        exp_q <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
        if (cmd_i.decide && (live_q >= CW'(srt_pkg::SLOTS))) free_q <= 1'b0;
        if (found_q)                                     stat_q <= srt_pkg::ST_FOUND;
        else if (!kind_q)                                stat_q <= srt_pkg::ST_ABSENT;
        else if ((quota_i != '0) && (same_q >= quota_i)) stat_q <= srt_pkg::ST_QUOTA;
        else if (!loop_ok_i && loop)                     stat_q <= srt_pkg::ST_LOOPBACK;
        else                                             stat_q <= srt_pkg::ST_ADDED;
      end
      if (cmd_i.write && !free_q) stat_q <= srt_pkg::ST_FULL;
      if (cmd_i.write && free_q)  slot_q <= free_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      live_q   <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_ptr_q <= '0;
    end else begin
      if (cmd_i.start || cmd_i.decide) begin
        ptr_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (step) begin
        rd_vld_q <= !ptr_q[SW];
        rd_ptr_q <= ptr_q[SW-1:0];
        if (!ptr_q[SW]) ptr_q <= ptr_q + 1'b1;
      end
      if (evict) begin
        used_q[rd_ptr_q] <= 1'b0;
        if (live_q != '0) live_q <= live_q - 1'b1;
      end
      if (cmd_i.write && free_q) begin
        used_q[free_slot_q] <= 1'b1;
        live_q              <= live_q + 1'b1;
      end
    end
  end

  // status, slot_index, bucket_hash, entry_count
  always_comb begin
    out_data_o = {live_q, bkt_q, 8'd0, stat_q};
    if ((stat_q == srt_pkg::ST_FOUND) || (stat_q == srt_pkg::ST_ADDED)) begin
      out_data_o[10:3] = slot_q;
    end
  end
endmodule

/* hw/rtl/server_registration_table_top.sv */
// Top level: hashed session table with timeout, stream in and out.
//
//  channel | group        | fields (lowest bit first)
//  --------+--------------+-----------------------------------------------------
//  request | s_axis_*     | tuser kind; tdata is_ipv6, has_mapping, addr_high,
//          |              | addr_low, port_number, scope_ident, now_seconds
//  result  | m_axis_*     | tdata status, slot_index, bucket_hash, entry_count
//  config  | cfg_*        | we, index (0 mix, 1 loopback, 2 quota, 3 lifetime)
//
// A request scans the table, one slot read a cycle through the single read port
// with registered read data, and then decides. A lookup or a refused add then
// gives its result; an add first writes its entry, and an add into a full table
// first sweeps the whole table again before the write. Reset clears the used bits
// and the live count at once; the entry memory holds no reset. The result waits
// in a register until taken, stalling the flow for as long as the stall lasts;
// the next request is accepted after that.
module server_registration_table_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [215:0] s_axis_tdata,  // is_ipv6, has_mapping, addr_high, addr_low,
                                      // port_number, scope_ident, now_seconds, pad
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // status, slot_index, bucket_hash, entry_count, pad
  input  logic         cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srt_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  logic       mix_q, loop_ok_q;
  logic [8:0] quota_q;
  logic [7:0] life_q;
  srt_pkg::cmd_t cmd;
  srt_pkg::sts_t sts;
  logic [srt_pkg::IN_TDATA_W-1:0] in_data;
  logic [srt_pkg::OUT_DATA_W-1:0] res;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q     <= 1'b0;
      loop_ok_q <= 1'b1;
      quota_q   <= 9'd32;
      life_q    <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        srt_pkg::CFG_MIX_PORT: mix_q     <= cfg_data_i[0];
        srt_pkg::CFG_LOOPBACK: loop_ok_q <= cfg_data_i[0];
        srt_pkg::CFG_QUOTA:    quota_q   <= cfg_data_i;
        srt_pkg::CFG_LIFETIME: life_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Repack into datapath order: has_mapping, is_ipv6, addr_high, addr_low, port, scope, now
  assign in_data = {s_axis_tdata[209:2], s_axis_tdata[0], s_axis_tdata[1]};

  srt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data),
    .in_kind_i  (s_axis_tuser),
    .mix_i      (mix_q),
    .loop_ok_i  (loop_ok_q),
    .quota_i    (quota_q),
    .life_i     (life_q),
    .out_data_o (res)
  );

  // status 2:0, slot 10:3, bucket 18:11, count 27:19
  assign m_axis_tdata = {4'd0, res};
endmodule

/* tb/sv/tb.sv */
// Testbench for the server registration table: directed and random requests checked by a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 600;  // a little over one add into a full table

  typedef struct {
    bit        kind;
    bit        v6;
    bit        mapped;
    bit [63:0] ah;
    bit [63:0] al;
    bit [15:0] port;
    bit [31:0] scope;
    bit [31:0] now;
  } req_t;

  typedef struct {
    bit [2:0] status;
    bit [7:0] slot;
    bit [7:0] bucket;
    bit [8:0] count;
  } res_t;

  // One row of the directed table: either a register write or a request.
  // Typed expectations of -1 leave that field to the predictor.
  typedef struct {
    bit                            is_cfg;
    logic [srt_pkg::CFG_IDX_W-1:0] idx;
    int                            val;
    req_t                          rq;
    int                            e_st;
    int                            e_slot;
    int                            e_cnt;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [215:0]                  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;
  logic                          cfg_we_i = 1'b0;
  logic [srt_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [srt_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;

  server_registration_table_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the session table, kept in step with every accepted request.
  bit        sh_used   [srt_pkg::SLOTS];
  bit        sh_family [srt_pkg::SLOTS];
  bit [63:0] sh_ah     [srt_pkg::SLOTS];
  bit [63:0] sh_al     [srt_pkg::SLOTS];
  bit [15:0] sh_port   [srt_pkg::SLOTS];
  bit [31:0] sh_scope  [srt_pkg::SLOTS];
  bit [31:0] sh_expiry [srt_pkg::SLOTS];
  bit [7:0]  sh_bucket [srt_pkg::SLOTS];
  int        sh_live;
  bit        mix_port  = 1'b0;
  bit        loop_ok   = 1'b1;
  int        quota     = 32;
  int        lifetime  = 2;

  res_t   pending_q[$];   // results still owed by the block
  int     errors = 0;
  int     n_items = 0;
  int     n_status[6];
  longint cycles = 0;
  bit     send_burst = 1'b0;
  bit     take_burst = 1'b0;
  row_t   rows[$];

  function automatic bit [7:0] bucket_of(bit v6, bit [63:0] ah, bit [15:0] port, bit mix);
    bit [31:0] h;
    h = v6 ? (ah[63:32] ^ ah[31:0]) : ah[31:0];
    if (mix) h = h ^ {16'h0, port};
    h = (h & 32'hFFFF) ^ (h >> 16);
    return 8'((h ^ (h >> 8)) & 32'hFF);
  endfunction

  function automatic void drop_slot(int i);
    sh_used[i] = 1'b0;
    if (sh_live > 0) sh_live--;
  endfunction

  // Work out the result of one request and update the shadow table.
  function automatic res_t table_lookup_add(req_t r);
    res_t      o;
    bit [63:0] ah, al;
    bit [31:0] scope, expiry;
    bit        found, loop;
    int        same, free;
    ah    = r.v6 ? r.ah : {32'h0, r.ah[31:0]};
    al    = r.v6 ? r.al : 64'h0;
    scope = r.v6 ? r.scope : 32'h0;
    o.bucket = bucket_of(r.v6, ah, r.port, mix_port);
    o.status = srt_pkg::ST_ABSENT;
    o.slot   = '0;
    found = 1'b0;
    same  = 0;
    for (int i = 0; i < srt_pkg::SLOTS; i++) begin
      if (!sh_used[i] || sh_family[i] != r.v6 || sh_bucket[i] != o.bucket) continue;
      if (sh_expiry[i] < r.now) begin
        drop_slot(i);
        continue;
      end
      if (sh_ah[i] == ah) begin
        same++;
        if (!found && sh_port[i] == r.port &&
            (!r.v6 || (sh_al[i] == al && sh_scope[i] == scope))) begin
          found  = 1'b1;
          o.slot = 8'(i);
        end
      end
    end
    if (found) begin
      o.status = srt_pkg::ST_FOUND;
    end else if (r.kind) begin
      loop = r.v6 ? (ah == 0 && al == 1) : (ah[31:24] == 8'd127 && !r.mapped);
      if (quota != 0 && same >= quota) begin
        o.status = srt_pkg::ST_QUOTA;
      end else if (!loop_ok && loop) begin
        o.status = srt_pkg::ST_LOOPBACK;
      end else begin
        if (sh_live >= srt_pkg::SLOTS)
          for (int i = 0; i < srt_pkg::SLOTS; i++)
            if (sh_used[i] && sh_expiry[i] < r.now) drop_slot(i);
        free = -1;
        for (int i = srt_pkg::SLOTS - 1; i >= 0; i--)
          if (!sh_used[i]) free = i;
        if (free < 0) begin
          o.status = srt_pkg::ST_FULL;
        end else begin
          expiry = r.now + 32'(lifetime);
          if (expiry < r.now) expiry = 32'hFFFF_FFFF;
          sh_used[free]   = 1'b1;
          sh_family[free] = r.v6;
          sh_ah[free]     = ah;
          sh_al[free]     = al;
          sh_port[free]   = r.port;
          sh_scope[free]  = scope;
          sh_expiry[free] = expiry;
          sh_bucket[free] = o.bucket;
          sh_live++;
          o.status = srt_pkg::ST_ADDED;
          o.slot   = 8'(free);
        end
      end
    end
    o.count = 9'(sh_live);
    return o;
  endfunction

  function automatic req_t v4_req(bit kind, bit mapped, bit [31:0] a, bit [15:0] port,
                                  bit [31:0] now);
    req_t r;
    r = '{kind: kind, v6: 1'b0, mapped: mapped, ah: {32'h0, a}, al: 64'h0,
          port: port, scope: 32'h0, now: now};
    return r;
  endfunction

  function automatic req_t v6_req(bit kind, bit [63:0] ah, bit [63:0] al, bit [15:0] port,
                                  bit [31:0] scope, bit [31:0] now);
    req_t r;
    r = '{kind: kind, v6: 1'b1, mapped: 1'($urandom), ah: ah, al: al,
          port: port, scope: scope, now: now};
    return r;
  endfunction

  function automatic void row_req(req_t r, int st, int slot, int cnt);
    row_t w;
    w = '{is_cfg: 1'b0, idx: '0, val: 0, rq: r, e_st: st, e_slot: slot, e_cnt: cnt};
    rows.push_back(w);
  endfunction

  function automatic void row_cfg(logic [srt_pkg::CFG_IDX_W-1:0] idx, int val);
    row_t w;
    w = '{is_cfg: 1'b1, idx: idx, val: val, rq: '{default: '0},
          e_st: -1, e_slot: -1, e_cnt: -1};
    rows.push_back(w);
  endfunction

  // Drop the request valid, then hold off until every owed result has been taken.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write a run of registers back to back; the enable drops only after the last.
  task automatic write_regs(logic [srt_pkg::CFG_IDX_W-1:0] idx[$], int val[$]);
    wait_idle();
    foreach (idx[k]) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= srt_pkg::CFG_DAT_W'(val[k]);
      case (idx[k])
        srt_pkg::CFG_MIX_PORT: mix_port = val[k][0];
        srt_pkg::CFG_LOOPBACK: loop_ok  = val[k][0];
        srt_pkg::CFG_QUOTA:    quota    = val[k] & 32'h1FF;
        default:               lifetime = val[k] & 32'hFF;
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Present one request, wait for the handshake, then predict and queue its result.
  task automatic send_req(req_t r, int st, int slot, int cnt);
    res_t e;
    int   gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {6'h0, r.now, r.scope, r.port, r.al, r.ah, r.mapped, r.v6};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    e = table_lookup_add(r);
    if (st >= 0)   e.status = 3'(st);
    if (slot >= 0) e.slot   = 8'(slot);
    if (cnt >= 0)  e.count  = 9'(cnt);
    pending_q.push_back(e);
    n_items++;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result side: random stalls, then compare each item with the oldest expectation.
  initial begin : result_checker
    res_t e;
    res_t got;
    int   stall;
    @(posedge rst_ni);
    forever begin
      stall = take_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.status = m_axis_tdata[2:0];
      got.slot   = m_axis_tdata[10:3];
      got.bucket = m_axis_tdata[18:11];
      got.count  = m_axis_tdata[27:19];
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing owed: %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (got.status <= srt_pkg::ST_FULL) n_status[got.status]++;
        if (got.status != e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
          errors++;
        end
        if (got.slot != e.slot) begin
          $display("%0t: slot expected %0d actual %0d", $realtime, e.slot, got.slot);
          errors++;
        end
        if (got.bucket != e.bucket) begin
          $display("%0t: bucket expected %0d actual %0d", $realtime, e.bucket, got.bucket);
          errors++;
        end
        if (got.count != e.count) begin
          $display("%0t: count expected %0d actual %0d", $realtime, e.count, got.count);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycles, pending_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random request: mostly a small pool of sources so that hits, quota and expiry occur.
  function automatic req_t random_req(ref bit [31:0] clock_s);
    bit [31:0] v4_pool[8] = '{32'h0A00_0001, 32'h0A00_0002, 32'h7F00_0001, 32'h7F12_3456,
                              32'hC0A8_0101, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0A00_0101};
    bit [63:0] v6_pool[4] = '{64'h0, 64'h2001_0DB8_0000_0001, 64'hFE80_0000_0000_0000,
                              64'hFFFF_FFFF_FFFF_FFFF};
    req_t r;
    int   pick;
    clock_s = clock_s + $urandom_range(0, 3);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // noise: every field at random, time included
      r = '{kind: 1'($urandom), v6: 1'($urandom), mapped: 1'($urandom),
            ah: {$urandom, $urandom}, al: {$urandom, $urandom}, port: 16'($urandom),
            scope: $urandom, now: $urandom};
    end else if (pick < 60) begin
      r = v4_req($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                 v4_pool[$urandom_range(0, 7)], 16'($urandom_range(0, 3)), clock_s);
      if ($urandom_range(0, 3) == 0) begin
        r.ah[63:32] = $urandom;   // ignored for IPv4
        r.al        = {$urandom, $urandom};
        r.scope     = $urandom;
      end
    end else begin
      r = v6_req($urandom_range(0, 3) != 0, v6_pool[$urandom_range(0, 3)],
                 $urandom_range(0, 3) == 0 ? 64'h1 : 64'($urandom_range(0, 2)),
                 16'($urandom_range(0, 3)), 32'($urandom_range(0, 1)), clock_s);
    end
    return r;
  endfunction

  initial begin : stimulus
    logic [srt_pkg::CFG_IDX_W-1:0] idx_q[$];
    int        val_q[$];
    int        quota_pick[7] = '{0, 1, 2, 3, 32, 256, 5};
    int        life_pick[6]  = '{0, 1, 2, 5, 255, 3};
    bit [31:0] clock_s;
    req_t      r;
    row_t      w;

    foreach (sh_used[i]) sh_used[i] = 1'b0;
    sh_live = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset configuration first: mix off, loopback allowed, quota 32, lifetime 2.
    row_req(v4_req(1'b0, 1'b0, 32'h0A00_0001, 16'd80, 32'd100), srt_pkg::ST_ABSENT, 0, 0);
    row_req(v4_req(1'b1, 1'b0, 32'h0A00_0001, 16'd80, 32'd100), srt_pkg::ST_ADDED, 0, 1);
    row_req(v4_req(1'b0, 1'b0, 32'h0A00_0001, 16'd80, 32'd101), srt_pkg::ST_FOUND, 0, 1);
    row_req(v4_req(1'b1, 1'b0, 32'h0A00_0001, 16'd81, 32'd101), srt_pkg::ST_ADDED, 1, 2);
    row_req(v6_req(1'b1, 64'h0, 64'h1, 16'd5, 32'd0, 32'd101), srt_pkg::ST_ADDED, 2, 3);
    row_req(v4_req(1'b1, 1'b0, 32'h7F00_0001, 16'd7, 32'd101), srt_pkg::ST_ADDED, 3, 4);
    // both entries for 10.0.0.1 have run out and are evicted on the way
    row_req(v4_req(1'b0, 1'b0, 32'h0A00_0001, 16'd80, 32'd200), srt_pkg::ST_ABSENT, 0, 2);
    row_cfg(srt_pkg::CFG_LOOPBACK, 0);
    row_req(v4_req(1'b1, 1'b0, 32'h7F12_3456, 16'd9, 32'd200), srt_pkg::ST_LOOPBACK, 0, -1);
    row_req(v4_req(1'b1, 1'b1, 32'h7F12_3456, 16'd9, 32'd200), srt_pkg::ST_ADDED, -1, -1);
    row_req(v6_req(1'b1, 64'h0, 64'h1, 16'd5, 32'd0, 32'd200), srt_pkg::ST_LOOPBACK, 0, -1);
    row_cfg(srt_pkg::CFG_QUOTA, 1);
    row_req(v4_req(1'b1, 1'b0, 32'h0A00_0009, 16'd1, 32'd200), srt_pkg::ST_ADDED, -1, -1);
    row_req(v4_req(1'b1, 1'b0, 32'h0A00_0009, 16'd2, 32'd200), srt_pkg::ST_QUOTA, 0, -1);
    row_cfg(srt_pkg::CFG_QUOTA, 0);
    row_cfg(srt_pkg::CFG_MIX_PORT, 1);
    row_cfg(srt_pkg::CFG_LIFETIME, 255);
    // expiry saturates at the top of the time range
    row_req(v6_req(1'b1, '1, '1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            srt_pkg::ST_ADDED, -1, -1);
    row_req(v6_req(1'b0, '1, '1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            srt_pkg::ST_FOUND, -1, -1);
    row_req(v4_req(1'b1, 1'b0, 32'h0, 16'h0, 32'h0), srt_pkg::ST_ADDED, -1, -1);
    row_cfg(srt_pkg::CFG_MIX_PORT, 0);
    row_cfg(srt_pkg::CFG_QUOTA, 256);
    row_cfg(srt_pkg::CFG_LIFETIME, 0);
    row_cfg(srt_pkg::CFG_LOOPBACK, 1);
    // IPv4 ignores the upper address bits, the host part and the scope
    r = v4_req(1'b1, 1'b0, 32'hFFFF_FFFF, 16'd3, 32'd300);
    r.ah = '1; r.al = 64'h1234; r.scope = 32'hABCD;
    row_req(r, srt_pkg::ST_ADDED, -1, -1);
    r.ah = 64'h5555_5555_FFFF_FFFF; r.al = 64'h0; r.scope = 32'h0; r.kind = 1'b0;
    row_req(r, srt_pkg::ST_FOUND, -1, -1);

    foreach (rows[k]) begin
      w = rows[k];
      if (w.is_cfg) begin
        idx_q = '{w.idx};
        val_q = '{w.val};
        write_regs(idx_q, val_q);
      end else begin
        send_req(w.rq, w.e_st, w.e_slot, w.e_cnt);
      end
    end

    // Random part: several settings in turn, one of them filling the table.
    clock_s = 32'd1000;
    for (int ph = 0; ph < 13; ph++) begin
      send_burst = ($urandom_range(0, 3) == 0);
      take_burst = ($urandom_range(0, 3) == 0);
      idx_q = '{srt_pkg::CFG_MIX_PORT, srt_pkg::CFG_LOOPBACK, srt_pkg::CFG_QUOTA,
                srt_pkg::CFG_LIFETIME};
      if (ph == 6) begin
        val_q = '{$urandom_range(0, 1), 1, 0, 255};
        write_regs(idx_q, val_q);
        clock_s = clock_s + 1000;
        // fill past capacity, then add again once everything has run out
        for (int n = 0; n < 275; n++) begin
          r = v4_req(1'b1, 1'b0, $urandom, 16'($urandom), clock_s);
          send_req(r, -1, -1, -1);
        end
        clock_s = clock_s + 300;
        for (int n = 0; n < 12; n++) begin
          r = random_req(clock_s);
          r.kind = 1'b1;
          send_req(r, -1, -1, -1);
        end
      end else begin
        val_q = '{ph[0], ph[1], quota_pick[ph % 7], life_pick[ph % 6]};
        if (ph > 8) val_q = '{$urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 256), $urandom_range(0, 255)};
        write_regs(idx_q, val_q);
        for (int n = 0; n < 130; n++) begin
          r = random_req(clock_s);
          send_req(r, -1, -1, -1);
        end
      end
    end
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests over 13 settings incl. a full table and its sweep;",
             n_items);
    $display("found %0d, added %0d, absent %0d, quota %0d, loopback %0d, full %0d",
             n_status[0], n_status[1], n_status[2], n_status[3], n_status[4], n_status[5]);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
